@@ sv/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types, status codes, result kinds and the status byte sizing helper.
// ----------------------------------------------------------------------------
package mtep_pkg;

  // Default width of the variable-length quantity accumulators.
  localparam int VlqBitsDefault = 28;

  // Width of the delta time reported with each result.
  localparam int DELTA_W = 28;

  // Parser phases, one-hot encoded.
  typedef enum logic [6:0] {
    PH_DELTA  = 7'b0000001,
    PH_STATUS = 7'b0000010,
    PH_DATA   = 7'b0000100,
    PH_MTYPE  = 7'b0001000,
    PH_LEN    = 7'b0010000,
    PH_SKIP   = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  // Result kinds.
  localparam logic [2:0] KIND_EVENT    = 3'd0;
  localparam logic [2:0] KIND_TOO_LONG = 3'd1;
  localparam logic [2:0] KIND_SKIPPED  = 3'd2;
  localparam logic [2:0] KIND_END      = 3'd3;
  localparam logic [2:0] KIND_STRAY    = 3'd4;

  // Status and meta codes.
  localparam logic [7:0] ST_NOTE_OFF    = 8'h80;
  localparam logic [3:0] ST_NOTE_ON_HI  = 4'h9;
  localparam logic [7:0] ST_SYSTEM      = 8'hF0;
  localparam logic [7:0] ST_SYSEX       = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC   = 8'hF7;
  localparam logic [7:0] ST_COMMON_LAST = 8'hF6;
  localparam logic [7:0] ST_META        = 8'hFF;
  localparam logic [7:0] META_END_TRACK = 8'h2F;
  localparam logic [6:0] VEL_RELEASE    = 7'h40;

  // Number of data bytes that follow a channel or system status byte.
  function automatic logic [1:0] data_len(input logic [7:0] s);
    logic [1:0] n;
    n = 2'd0;
    if (s < ST_SYSTEM) begin
      unique case (s[7:4]) inside
        4'hC, 4'hD: n = 2'd1;
        default:    n = 2'd2;
      endcase
    end else begin
      unique case (s) inside
        8'hF1, 8'hF3: n = 2'd1;
        8'hF2:        n = 2'd2;
        default:      n = 2'd0;
      endcase
    end
    return n;
  endfunction

endpackage

@@ sv/midi_track_event_parser.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser
// Decodes track event bytes into one result per finished event.
// ----------------------------------------------------------------------------
// The parser takes one byte of track event data per clock cycle, save when a
// finishing byte stalls: every byte is decoded in the cycle it is accepted,
// and a finished event is written to a single result register. A byte that
// finishes no event is accepted even while a result waits to be taken; only a
// byte that finishes an event waits, and only while the result register is
// full and not being drained. Results therefore appear in the cycle after the
// byte that completes the event. Delta times and meta or sysex lengths are
// accumulated over VLQ_BITS bits; the delta time is reported in 28 bits.
// Configuration writes take effect at the next clock edge.
module midi_track_event_parser #(
  parameter int VLQ_BITS = mtep_pkg::VlqBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  // Configuration
  input  logic       cfg_write,
  input  logic [1:0] cfg_data,
  // Byte request channel
  input  logic       data_valid,
  output logic       data_ready,
  input  logic [7:0] data_byte,
  input  logic       track_start,
  // Result request channel
  output logic       result_valid,
  input  logic       result_ready,
  output logic [2:0] kind,
  output logic [mtep_pkg::DELTA_W-1:0] delta_ticks,
  output logic [7:0] status_byte,
  output logic [6:0] first_data,
  output logic [6:0] second_data,
  output logic [1:0] event_size
);
  import mtep_pkg::*;

  // Parser state.
  logic [1:0]          max_event_len;
  phase_t              phase;
  logic [VLQ_BITS-1:0] delta_accum;
  logic [7:0]          running_status;
  logic [7:0]          current_status;
  logic [1:0]          bytes_needed;
  logic [1:0]          byte_index;
  logic [6:0]          held_first;
  logic [VLQ_BITS-1:0] length_accum;
  logic                is_end_meta;

  // State after an optional track restart.
  phase_t              phase_cur;
  logic [VLQ_BITS-1:0] delta_cur;
  logic [7:0]          running_cur;
  logic [7:0]          current_cur;
  logic [1:0]          needed_cur;
  logic [1:0]          index_cur;
  logic [6:0]          held_cur;
  logic [VLQ_BITS-1:0] length_cur;
  logic                end_meta_cur;

  // Next state.
  phase_t              phase_next;
  logic [VLQ_BITS-1:0] delta_accum_next;
  logic [7:0]          running_status_next;
  logic [7:0]          current_status_next;
  logic [1:0]          bytes_needed_next;
  logic [1:0]          byte_index_next;
  logic [6:0]          held_first_next;
  logic [VLQ_BITS-1:0] length_accum_next;
  logic                is_end_meta_next;

  // Event completion and the result it produces.
  logic                fin_event;
  logic                fin_meta;
  logic                fin_stray;
  logic                emit_now;
  logic [6:0]          fin_second;
  logic [1:0]          ev_size;
  logic [6:0]          ev_first;
  logic [2:0]          kind_next;
  logic [7:0]          status_byte_next;
  logic [6:0]          first_data_next;
  logic [6:0]          second_data_next;
  logic [1:0]          event_size_next;
  logic                accept;

  // A track start clears the parser before the byte is decoded.
  always_comb begin
    if (track_start) begin
      phase_cur    = PH_DELTA;
      delta_cur    = '0;
      running_cur  = '0;
      current_cur  = '0;
      needed_cur   = '0;
      index_cur    = '0;
      held_cur     = '0;
      length_cur   = '0;
      end_meta_cur = 1'b0;
    end else begin
      phase_cur    = phase;
      delta_cur    = delta_accum;
      running_cur  = running_status;
      current_cur  = current_status;
      needed_cur   = bytes_needed;
      index_cur    = byte_index;
      held_cur     = held_first;
      length_cur   = length_accum;
      end_meta_cur = is_end_meta;
    end
  end

  // Byte decode for the current phase.
  always_comb begin
    phase_next          = phase_cur;
    delta_accum_next    = delta_cur;
    running_status_next = running_cur;
    current_status_next = current_cur;
    bytes_needed_next   = needed_cur;
    byte_index_next     = index_cur;
    held_first_next     = held_cur;
    length_accum_next   = length_cur;
    is_end_meta_next    = end_meta_cur;
    fin_event           = 1'b0;
    fin_meta            = 1'b0;
    fin_stray           = 1'b0;
    fin_second          = '0;

    unique case (phase_cur)
      PH_DELTA: begin
        delta_accum_next = {delta_cur[VLQ_BITS-8:0], data_byte[6:0]};
        if (!data_byte[7]) begin
          phase_next = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (!data_byte[7]) begin
          // Data byte: running status applies, or it is a stray byte.
          if (running_cur == '0) begin
            fin_stray = 1'b1;
          end else begin
            current_status_next = running_cur;
            bytes_needed_next   = data_len(running_cur);
            held_first_next     = data_byte[6:0];
            byte_index_next     = 2'd1;
            if (data_len(running_cur) <= 2'd1) begin
              fin_event = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end else begin
          current_status_next = data_byte;
          if (data_byte == ST_META) begin
            phase_next = PH_MTYPE;
          end else if (data_byte == ST_SYSEX || data_byte == ST_SYSEX_ESC) begin
            is_end_meta_next  = 1'b0;
            length_accum_next = '0;
            phase_next        = PH_LEN;
          end else begin
            // Channel statuses set running status, system common clears it.
            if (data_byte < ST_SYSTEM) begin
              running_status_next = data_byte;
            end else if (data_byte <= ST_COMMON_LAST) begin
              running_status_next = '0;
            end
            bytes_needed_next = data_len(data_byte);
            byte_index_next   = 2'd0;
            if (data_len(data_byte) == 2'd0) begin
              fin_event = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        if (index_cur == 2'd0) begin
          held_first_next = data_byte[6:0];
          byte_index_next = 2'd1;
          if (needed_cur <= 2'd1) begin
            fin_event = 1'b1;
          end
        end else begin
          byte_index_next = 2'd2;
          fin_second      = data_byte[6:0];
          fin_event       = 1'b1;
        end
      end
      PH_MTYPE: begin
        is_end_meta_next  = (data_byte == META_END_TRACK);
        length_accum_next = '0;
        phase_next        = PH_LEN;
      end
      PH_LEN: begin
        length_accum_next = {length_cur[VLQ_BITS-8:0], data_byte[6:0]};
        if (!data_byte[7]) begin
          if ({length_cur[VLQ_BITS-8:0], data_byte[6:0]} == '0) begin
            fin_meta = 1'b1;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        length_accum_next = length_cur - VLQ_BITS'(1);
        if (length_cur == VLQ_BITS'(1)) begin
          fin_meta = 1'b1;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DELTA;
      end
    endcase
  end

  // Result formation.
  always_comb begin
    emit_now         = fin_event | fin_meta | fin_stray;
    ev_size          = bytes_needed_next + 2'd1;
    ev_first         = (bytes_needed_next != 2'd0) ? held_first_next : 7'd0;
    kind_next        = KIND_EVENT;
    status_byte_next = current_status_next;
    first_data_next  = '0;
    second_data_next = '0;
    event_size_next  = '0;

    if (fin_stray) begin
      kind_next        = KIND_STRAY;
      status_byte_next = '0;
      first_data_next  = data_byte[6:0];
    end else if (fin_meta) begin
      kind_next = is_end_meta_next ? KIND_END : KIND_SKIPPED;
    end else if (ev_size > max_event_len) begin
      kind_next       = KIND_TOO_LONG;
      event_size_next = ev_size;
    end else begin
      kind_next        = KIND_EVENT;
      first_data_next  = ev_first;
      second_data_next = fin_second;
      event_size_next  = ev_size;
      // A note-on with velocity zero is reported as a note-off.
      if (ev_size == 2'd3 && current_status_next[7:4] == ST_NOTE_ON_HI &&
          fin_second == 7'd0) begin
        status_byte_next = ST_NOTE_OFF | {4'h0, current_status_next[3:0]};
        second_data_next = VEL_RELEASE;
      end
    end
  end

  // Only a byte that finishes an event waits on a full result register.
  assign data_ready = !result_valid || result_ready || !emit_now;
  assign accept     = data_valid && data_ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_event_len <= 2'd3;
    end else if (cfg_write) begin
      max_event_len <= cfg_data;
    end
  end

  // Parser state registers; an emitted result clears the event fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      delta_accum    <= '0;
      running_status <= '0;
      current_status <= '0;
      bytes_needed   <= '0;
      byte_index     <= '0;
      held_first     <= '0;
      length_accum   <= '0;
      is_end_meta    <= 1'b0;
    end else if (accept) begin
      running_status <= running_status_next;
      current_status <= current_status_next;
      if (emit_now) begin
        phase        <= (kind_next == KIND_END) ? PH_DONE : PH_DELTA;
        delta_accum  <= '0;
        bytes_needed <= '0;
        byte_index   <= '0;
        held_first   <= '0;
        length_accum <= '0;
        is_end_meta  <= 1'b0;
      end else begin
        phase        <= phase_next;
        delta_accum  <= delta_accum_next;
        bytes_needed <= bytes_needed_next;
        byte_index   <= byte_index_next;
        held_first   <= held_first_next;
        length_accum <= length_accum_next;
        is_end_meta  <= is_end_meta_next;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && emit_now) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept && emit_now) begin
      kind        <= kind_next;
      delta_ticks <= DELTA_W'(delta_cur);
      status_byte <= status_byte_next;
      first_data  <= first_data_next;
      second_data <= second_data_next;
      event_size  <= event_size_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A byte taken while a result is stalled must not finish an event.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready && accept) |-> !emit_now)
    else $error("byte accepted over a stalled result finished an event");

  // A track start leaves the parser reading a delta time or a status.
  a_track_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && track_start) |=> (phase == PH_DELTA || phase == PH_STATUS))
    else $error("track start did not restart the parser");

  // A delivered event always carries its status byte in its size.
  a_event_size: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_EVENT) |-> (event_size != 2'd0))
    else $error("delivered event with zero size");

  // A delivered three-byte note-on never carries velocity zero.
  a_note_on_vel: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_EVENT && event_size == 2'd3 &&
     status_byte[7:4] == ST_NOTE_ON_HI) |-> (second_data != 7'd0))
    else $error("note-on with velocity zero was not converted");

  // Nothing but a track start finishes an event after end of track.
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE && !track_start) |-> !emit_now)
    else $error("result produced after end of track");
`endif

endmodule
